FILE: rtl/core/cdfg_pkg.sv
// Shared types, codes and frame-building functions for the clock display frame generator.
// No dependencies; every other file in rtl/core imports this package.
package cdfg_pkg;

  // Action codes carried on the input tuser
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_INIT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOINIT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Display command and address bytes
  localparam logic [7:0] CMD_DATA       = 8'h40;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
  localparam logic [7:0] ADDR_DIG0      = 8'hC0;
  localparam logic [7:0] ADDR_DIG1      = 8'hC1;

  // Segment bytes for the start-up word
  localparam logic [7:0] SEG_S    = 8'hED;
  localparam logic [7:0] SEG_T    = 8'h78;
  localparam logic [7:0] SEG_R    = 8'h50;
  localparam logic [7:0] DOT_MASK = 8'h80;

  localparam logic [5:0] MAX_MINUTE = 6'd59;
  localparam logic [4:0] MAX_HOUR   = 5'd23;

  // Work handed from the front end to the back end
  typedef enum logic [2:0] {
    JOB_TICK_DOT,
    JOB_TICK_FULL,
    JOB_SET_TIME,
    JOB_NOINIT,
    JOB_REJECT,
    JOB_INIT_FULL,
    JOB_INIT_STRT
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [1:0]  h_tens;
    logic [3:0]  h_ones;
    logic [2:0]  m_tens;
    logic [3:0]  m_ones;
    logic        dot;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       has_second;
    logic [1:0] status;
  } frame_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Seven-segment code for a decimal digit, dot bit clear
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Split a value below 60 into tens and ones
  function automatic digits_t split_digits(input logic [5:0] v);
    digits_t    r;
    logic [5:0] tens10;
    priority if (v >= 6'd50) begin
      r.tens = 3'd5; tens10 = 6'd50;
    end else if (v >= 6'd40) begin
      r.tens = 3'd4; tens10 = 6'd40;
    end else if (v >= 6'd30) begin
      r.tens = 3'd3; tens10 = 6'd30;
    end else if (v >= 6'd20) begin
      r.tens = 3'd2; tens10 = 6'd20;
    end else if (v >= 6'd10) begin
      r.tens = 3'd1; tens10 = 6'd10;
    end else begin
      r.tens = 3'd0; tens10 = 6'd0;
    end
    r.ones = 4'(v - tens10);
    return r;
  endfunction

  // Index of the final frame of a job
  function automatic logic [3:0] job_last(input job_kind_t k);
    logic [3:0] n;
    unique case (k)
      JOB_TICK_DOT:  n = 4'd0;
      JOB_TICK_FULL: n = 4'd4;
      JOB_SET_TIME:  n = 4'd3;
      JOB_NOINIT:    n = 4'd0;
      JOB_REJECT:    n = 4'd0;
      JOB_INIT_FULL: n = 4'd9;
      JOB_INIT_STRT: n = 4'd3;
      default:       n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic frame_t data_frame(input logic [7:0] addr, input logic [7:0] seg);
    frame_t f;
    f.first      = addr;
    f.second     = seg;
    f.has_second = 1'b1;
    f.status     = ST_OK;
    return f;
  endfunction

  function automatic frame_t cmd_frame(input logic [7:0] cmd);
    frame_t f;
    f.first      = cmd;
    f.second     = 8'h00;
    f.has_second = 1'b0;
    f.status     = ST_OK;
    return f;
  endfunction

  function automatic frame_t status_frame(input logic [1:0] st);
    frame_t f;
    f.first      = 8'h00;
    f.second     = 8'h00;
    f.has_second = 1'b0;
    f.status     = st;
    return f;
  endfunction

  // One digit of the current time at display position pos
  function automatic frame_t time_frame(input job_t j, input logic [1:0] pos);
    logic [3:0] d;
    unique case (pos)
      2'd0:    d = {2'b00, j.h_tens};
      2'd1:    d = j.h_ones;
      2'd2:    d = {1'b0, j.m_tens};
      default: d = j.m_ones;
    endcase
    return data_frame(ADDR_DIG0 | {6'd0, pos}, seg_code(d));
  endfunction

  // One letter of the start-up word at display position pos
  function automatic frame_t strt_frame(input logic [1:0] pos);
    logic [7:0] s;
    unique case (pos)
      2'd0:    s = SEG_S;
      2'd1:    s = SEG_T;
      2'd2:    s = SEG_R;
      default: s = SEG_T;
    endcase
    return data_frame(ADDR_DIG0 | {6'd0, pos}, s);
  endfunction

  // Second hour digit with the blinking dot
  function automatic frame_t dot_frame(input job_t j);
    logic [7:0] s;
    s = seg_code(j.h_ones);
    if (j.dot) s = s ^ DOT_MASK;
    return data_frame(ADDR_DIG1, s);
  endfunction

  // Frame number step of a job
  function automatic frame_t gen_frame(input job_t j, input logic [3:0] step);
    frame_t     f;
    logic [1:0] ipos;
    logic [1:0] spos;
    ipos = 2'(step - 4'd1);
    spos = 2'(step - 4'd6);
    unique case (j.kind)
      JOB_TICK_DOT:  f = dot_frame(j);
      JOB_TICK_FULL: f = (step < 4'd4) ? time_frame(j, step[1:0]) : dot_frame(j);
      JOB_SET_TIME:  f = time_frame(j, step[1:0]);
      JOB_NOINIT:    f = status_frame(ST_NOINIT);
      JOB_REJECT:    f = status_frame(ST_REJECT);
      JOB_INIT_FULL: begin
        priority if (step == 4'd0)  f = cmd_frame(CMD_DATA);
        else if (step < 4'd5)      f = data_frame(ADDR_DIG0 | {6'd0, ipos}, seg_code(4'd0));
        else if (step == 4'd5)     f = cmd_frame(CMD_DISPLAY_ON);
        else                       f = strt_frame(spos);
      end
      JOB_INIT_STRT: f = strt_frame(step[1:0]);
      default:       f = status_frame(ST_OK);
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/core/cdfg_front.sv
// Front end: accepts actions, keeps the clock and display state, queues at most one job per action.
// Depends on cdfg_pkg.
module cdfg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_tuser,   // [1:0] action
  input  logic [15:0]         in_tdata,   // [4:0] new_hours, [10:5] new_minutes, [15:11] zero
  input  logic                q_full,
  output cdfg_pkg::job_push_t push
);
  import cdfg_pkg::*;

  logic [5:0] seconds_r, seconds_nxt;
  logic [5:0] minutes_r, minutes_nxt;
  logic [4:0] hours_r, hours_nxt;
  logic       running_r, running_nxt;
  logic       ready_r, ready_nxt;
  logic       dot_r, dot_nxt;

  logic       accept;
  logic [1:0] action;
  logic [4:0] new_hours;
  logic [5:0] new_minutes;
  logic       minute_wrap;
  logic       hour_carry;
  digits_t    hd;
  digits_t    md;

  assign in_tready   = !q_full;
  assign accept      = in_tvalid && in_tready;
  assign action      = in_tuser;
  assign new_hours   = in_tdata[4:0];
  assign new_minutes = in_tdata[10:5];
  assign minute_wrap = (seconds_r == MAX_MINUTE);
  assign hour_carry  = minute_wrap && (minutes_r == MAX_MINUTE);

  // Next state and the job for this action
  always_comb begin
    seconds_nxt = seconds_r;
    minutes_nxt = minutes_r;
    hours_nxt   = hours_r;
    running_nxt = running_r;
    ready_nxt   = ready_r;
    dot_nxt     = dot_r;
    push.valid  = 1'b0;
    push.job    = '0;
    hd          = split_digits({1'b0, hours_r});
    md          = split_digits(minutes_r);
    if (accept) begin
      unique case (action)
        ACT_TICK: begin
          if (running_r) begin
            seconds_nxt = minute_wrap ? 6'd0 : seconds_r + 6'd1;
            if (minute_wrap) minutes_nxt = hour_carry ? 6'd0 : minutes_r + 6'd1;
            if (hour_carry)  hours_nxt = (hours_r == MAX_HOUR) ? 5'd0 : hours_r + 5'd1;
            dot_nxt    = !dot_r;
            hd         = split_digits({1'b0, hours_nxt});
            md         = split_digits(minutes_nxt);
            push.valid = ready_r;
            push.job.kind = minute_wrap ? JOB_TICK_FULL : JOB_TICK_DOT;
          end
        end
        ACT_SET: begin
          push.valid = 1'b1;
          if (new_hours > MAX_HOUR || new_minutes > MAX_MINUTE) begin
            push.job.kind = JOB_REJECT;
          end else begin
            hours_nxt     = new_hours;
            minutes_nxt   = new_minutes;
            seconds_nxt   = 6'd0;
            running_nxt   = 1'b1;
            hd            = split_digits({1'b0, new_hours});
            md            = split_digits(new_minutes);
            push.job.kind = ready_r ? JOB_SET_TIME : JOB_NOINIT;
          end
        end
        ACT_INIT: begin
          push.valid    = 1'b1;
          push.job.kind = ready_r ? JOB_INIT_STRT : JOB_INIT_FULL;
          ready_nxt     = 1'b1;
        end
        default: ;
      endcase
    end
    push.job.h_tens = hd.tens[1:0];
    push.job.h_ones = hd.ones;
    push.job.m_tens = md.tens;
    push.job.m_ones = md.ones;
    push.job.dot    = dot_r;
  end

  // Hold clock and display state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_r <= '0;
      minutes_r <= '0;
      hours_r   <= '0;
      running_r <= 1'b0;
      ready_r   <= 1'b0;
      dot_r     <= 1'b0;
    end else begin
      seconds_r <= seconds_nxt;
      minutes_r <= minutes_nxt;
      hours_r   <= hours_nxt;
      running_r <= running_nxt;
      ready_r   <= ready_nxt;
      dot_r     <= dot_nxt;
    end
  end

endmodule

FILE: rtl/core/cdfg_queue.sv
// Job queue between front end and back end.
// Depends on cdfg_pkg.
module cdfg_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cdfg_pkg::job_push_t push,
  output logic                full,
  output cdfg_pkg::job_head_t head,
  input  logic                pop
);
  import cdfg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.job   = mem[rd_ptr_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && head.valid;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push.job;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop)      count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

FILE: rtl/core/cdfg_back.sv
// Back end: expands queued jobs into frames in an output register, one per cycle unless stalled.
// Depends on cdfg_pkg.
module cdfg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cdfg_pkg::job_head_t head,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // [7:0] frame_first, [15:8] frame_second
  output logic [2:0]          out_tuser,  // [0] has_second, [2:1] status
  output logic                out_tlast
);
  import cdfg_pkg::*;

  logic [3:0] step_r;
  logic       valid_r;
  frame_t     frame_r;
  logic       last_r;
  logic       load;
  logic       at_last;
  frame_t     frame_nxt;

  assign load      = head.valid && (!valid_r || out_tready);
  assign at_last   = (step_r == job_last(head.job.kind));
  assign frame_nxt = gen_frame(head.job, step_r);
  assign pop       = load && at_last;

  // Step through the frames of the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) step_r <= at_last ? 4'd0 : step_r + 4'd1;
      if (load)            valid_r <= 1'b1;
      else if (out_tready) valid_r <= 1'b0;
    end
  end

  // Hold the frame until transfer
  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame_nxt;
      last_r  <= at_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {frame_r.second, frame_r.first};
  assign out_tuser  = {frame_r.status, frame_r.has_second};
  assign out_tlast  = last_r;

endmodule

FILE: rtl/core/clock_display_frame_generator.sv
// Top level of the clock display frame generator: front end, job queue, back end.
// Depends on cdfg_pkg, cdfg_front, cdfg_queue and cdfg_back.
//
//  channel | direction | tdata                              | tuser                     | tlast
//  in_     | input     | [4:0] new_hours, [10:5] new_minutes| [1:0] action              | -
//  out_    | output    | [7:0] frame_first, [15:8] frame_sec| [0] has_second,[2:1] status| last
//
// An accepted action updates the registered clock state on the accepting edge; it queues at most one job.
// The back end sends one frame per cycle while out_tready stays high; a job has 1 to 10 frames.
// Up to QUEUE_DEPTH jobs wait between the two sides; in_tready drops only when the queue is full.
// rst_n is synchronous, active low, and clears the clock, flags, queue, frame step and output valid.
// A stall on out_tready holds the current frame and backs up into the queue.
module clock_display_frame_generator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic [15:0] in_tdata,   // [4:0] new_hours, [10:5] new_minutes, [15:11] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_first, [15:8] frame_second
  output logic [2:0]  out_tuser,  // [0] has_second, [2:1] status
  output logic        out_tlast
);
  import cdfg_pkg::*;

  job_push_t push;
  job_head_t head;
  logic      q_full;
  logic      pop;

  cdfg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push)
  );

  cdfg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  cdfg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
